@@ sv/laplace_5point_stencil_core_defines.svh @@
// Assertion macros for the five-point Laplacian stencil core.
// No dependencies; included by the top level wherever it checks itself.
`ifndef LAPLACE_5POINT_STENCIL_CORE_DEFINES_SVH
`define LAPLACE_5POINT_STENCIL_CORE_DEFINES_SVH

// Check that cons holds whenever ante holds, outside reset.
`define LPS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cond never holds, outside reset.
`define LPS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ sv/lps_pkg.sv @@
// Shared types and constants of the five-point Laplacian stencil core.
// No dependencies; the front, queue, back and top files import it, lps_ifs refers to it.
package lps_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_H_SQUARED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_BORDER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEGATE_RESULT = 3'd4;

    // Field widths fixed by the register map
    localparam int COLS_W   = 11;
    localparam int ROWS_W   = 16;
    localparam int ROW_CNT_W = ROWS_W + 1;
    localparam int DATA_W   = 32;
    localparam int VSUM_W   = DATA_W + 1;
    localparam int LAP_W    = DATA_W + 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Saturation limits
    localparam logic [DATA_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VALUE_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [COLS_W-1:0] grid_cols;
        logic [ROWS_W-1:0] grid_rows;
        logic              zero_border;
        logic              restart;
    } front_cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] inv_h_squared;
        logic              negate_result;
    } back_cfg_t;

    typedef struct packed {
        logic signed [LAP_W-1:0] lap;
        logic                    frame_last;
    } lap_word_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } q_status_t;

endpackage

@@ sv/lps_ifs.sv @@
// Valid/ready channel interfaces of the stencil core: samples, results, config writes.
// Depends on lps_pkg for the register index width.
interface lps_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface lps_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               frame_last;
    logic               saturated;

    modport source (output valid, output value, output frame_last, output saturated,
                    input ready);
    modport sink   (input valid, input value, input frame_last, input saturated,
                    output ready);
endinterface

interface lps_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lps_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/lps_front.sv @@
// Front end: raster position, ghost handling, line memory and window; yields the raw
// Laplacian for each interior point. Depends on lps_pkg and lps_sample_if.
module lps_front #(
    parameter int MAX_COLS = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lps_sample_if.sink            samples,
    input  lps_pkg::front_cfg_t   fcfg,
    input  lps_pkg::q_status_t    q_status,
    output logic                  push,
    output lps_pkg::lap_word_t    push_word
);
    import lps_pkg::*;

    localparam int LINE_DEPTH = MAX_COLS + 2;
    localparam int CW         = $clog2(LINE_DEPTH);

    // Effective geometry
    logic [CW-1:0]        eff_cols;
    logic [CW-1:0]        last_col;
    logic [ROWS_W-1:0]    eff_rows;
    logic [ROW_CNT_W-1:0] last_row;

    always_comb
    begin
        priority if (fcfg.grid_cols == '0)
            eff_cols = CW'(1);
        else if (32'(fcfg.grid_cols) > 32'(MAX_COLS))
            eff_cols = CW'(MAX_COLS);
        else
            eff_cols = CW'(fcfg.grid_cols);
        eff_rows = (fcfg.grid_rows == '0) ? ROWS_W'(1) : fcfg.grid_rows;
        last_col = eff_cols + CW'(1);
        last_row = {1'b0, eff_rows} + ROW_CNT_W'(1);
    end

    // Position counters
    logic [CW-1:0]        col_reg, col_next;
    logic [ROW_CNT_W-1:0] row_reg, row_next;
    logic                 accept;
    logic                 s1_valid_reg;
    logic [QCNT_W:0]      slots_used;

    // Take a word only when the queue can hold every result in flight
    assign slots_used    = {1'b0, q_status.count} + {{QCNT_W{1'b0}}, s1_valid_reg};
    assign samples.ready = slots_used < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept        = samples.valid && samples.ready;

    logic              ghost;
    logic              emit;
    logic              at_last;
    logic [DATA_W-1:0] raw;

    always_comb
    begin
        ghost   = (row_reg == '0) || (row_reg == last_row) ||
                  (col_reg == '0) || (col_reg == last_col);
        emit    = (row_reg >= ROW_CNT_W'(2)) && (col_reg >= CW'(2));
        at_last = (row_reg == last_row) && (col_reg == last_col);
        raw     = (fcfg.zero_border && ghost) ? '0 : samples.sample;
    end

    // Advance raster position; restart on a geometry write
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (fcfg.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                row_next = (row_reg == last_row) ? '0 : row_reg + ROW_CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
        end
    end

    // Stage-1 payload
    logic [DATA_W-1:0] s1_raw_reg;
    logic [CW-1:0]     s1_addr_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_raw_reg  <= raw;
            s1_addr_reg <= col_reg;
            s1_emit_reg <= emit;
            s1_last_reg <= at_last;
        end
    end

    // Line memory: upper half two rows back, lower half one row back
    logic [2*DATA_W-1:0] line_mem [LINE_DEPTH];
    logic [2*DATA_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= line_mem[col_reg];
        if (s1_valid_reg)
            line_mem[s1_addr_reg] <= {rd_reg[DATA_W-1:0], s1_raw_reg};
    end

    // Window along the middle row and north+south of the previous column
    logic signed [DATA_W-1:0] west_reg, center_reg;
    logic signed [VSUM_W-1:0] vsum_reg;
    logic signed [DATA_W-1:0] north, middle, s1_south;
    logic signed [VSUM_W-1:0] vsum_next;

    assign north     = rd_reg[2*DATA_W-1:DATA_W];
    assign middle    = rd_reg[DATA_W-1:0];
    assign s1_south  = s1_raw_reg;
    assign vsum_next = {north[DATA_W-1], north} + {s1_south[DATA_W-1], s1_south};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            west_reg   <= '0;
            center_reg <= '0;
            vsum_reg   <= '0;
        end
        else if (s1_valid_reg)
        begin
            west_reg   <= center_reg;
            center_reg <= middle;
            vsum_reg   <= vsum_next;
        end
    end

    // Laplacian: 4*center - west - east - (north + south)
    logic signed [LAP_W-1:0] c4, w_x, e_x, v_x;

    always_comb
    begin
        c4 = {center_reg[DATA_W-1], center_reg, 2'b00};
        w_x = {{3{west_reg[DATA_W-1]}}, west_reg};
        e_x = {{3{middle[DATA_W-1]}}, middle};
        v_x = {{2{vsum_reg[VSUM_W-1]}}, vsum_reg};
        push_word.lap        = c4 - w_x - e_x - v_x;
        push_word.frame_last = s1_last_reg;
        push                 = s1_valid_reg && s1_emit_reg;
    end

endmodule

@@ sv/lps_queue.sv @@
// Short FIFO of Laplacian words between the front and back ends.
// Depends on lps_pkg.
module lps_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lps_pkg::lap_word_t push_word,
    input  logic               pop,
    output lps_pkg::lap_word_t head,
    output lps_pkg::q_status_t status
);
    import lps_pkg::*;

    lap_word_t         entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_word;
    end

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    assign head         = entries[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;

endmodule

@@ sv/lps_back.sv @@
// Back end: scales the Laplacian by 1/h^2, rounds to Q16.16, optionally negates, saturates.
// Depends on lps_pkg and lps_result_if.
module lps_back (
    input  logic               clk,
    input  logic               rst_n,
    input  lps_pkg::back_cfg_t bcfg,
    input  lps_pkg::lap_word_t head,
    input  lps_pkg::q_status_t q_status,
    output logic               pop,
    lps_result_if.source       results
);
    import lps_pkg::*;

    localparam int MAG_W  = LAP_W;
    localparam int LO_W   = 17;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PLO_W  = LO_W + DATA_W;
    localparam int PHI_W  = HI_W + DATA_W;
    localparam int FULL_W = MAG_W + DATA_W;
    localparam int Q_W    = FULL_W - 16;

    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic a_ready, b_ready, c_ready;

    // Stage handshakes: a stage moves when the one after it is free or moving
    assign c_ready = !c_valid_reg || results.ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign pop     = !q_status.empty && a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= pop;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    // Stage A: sign and magnitude
    logic [MAG_W-1:0] a_mag_reg, a_mag_next;
    logic             a_neg_reg, a_last_reg;

    assign a_mag_next = head.lap[LAP_W-1] ? MAG_W'(-head.lap) : MAG_W'(head.lap);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_mag_reg  <= a_mag_next;
            a_neg_reg  <= head.lap[LAP_W-1] ^ bcfg.negate_result;
            a_last_reg <= head.frame_last;
        end
    end

    // Stage B: two partial products of magnitude times scale
    logic [PLO_W-1:0] b_plo_reg, b_plo_next;
    logic [PHI_W-1:0] b_phi_reg, b_phi_next;
    logic             b_neg_reg, b_last_reg;

    assign b_plo_next = {{DATA_W{1'b0}}, a_mag_reg[LO_W-1:0]} *
                        {{LO_W{1'b0}}, bcfg.inv_h_squared};
    assign b_phi_next = {{DATA_W{1'b0}}, a_mag_reg[MAG_W-1:LO_W]} *
                        {{HI_W{1'b0}}, bcfg.inv_h_squared};

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_plo_reg  <= b_plo_next;
            b_phi_reg  <= b_phi_next;
            b_neg_reg  <= a_neg_reg;
            b_last_reg <= a_last_reg;
        end
    end

    // Stage C: sum, round half away from zero, clip
    logic [FULL_W-1:0] full_sum;
    logic [Q_W-1:0]    q;
    logic [DATA_W-1:0] value_next;
    logic              sat_next;

    always_comb
    begin
        full_sum = {b_phi_reg, {LO_W{1'b0}}} + {{(FULL_W - PLO_W){1'b0}}, b_plo_reg}
                   + FULL_W'(32'h8000);
        q        = full_sum[FULL_W-1:16];
        if (b_neg_reg)
        begin
            sat_next   = q > Q_W'(VALUE_MIN);
            value_next = sat_next ? VALUE_MIN : (~q[DATA_W-1:0] + DATA_W'(1));
        end
        else
        begin
            sat_next   = q > Q_W'(VALUE_MAX);
            value_next = sat_next ? VALUE_MAX : q[DATA_W-1:0];
        end
    end

    logic [DATA_W-1:0] c_value_reg;
    logic              c_sat_reg, c_last_reg;

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_value_reg <= value_next;
            c_sat_reg   <= sat_next;
            c_last_reg  <= b_last_reg;
        end
    end

    assign results.valid      = c_valid_reg;
    assign results.value      = c_value_reg;
    assign results.saturated  = c_sat_reg;
    assign results.frame_last = c_last_reg;

endmodule

@@ sv/laplace_5point_stencil_core.sv @@
// Five-point Laplacian stencil core: config registers, front end, queue, back end.
// Depends on lps_pkg, lps_ifs, lps_front, lps_queue, lps_back and the assertion macros.
//
// Use: stream a ghosted grid of (grid_rows+2) x (grid_cols+2) signed Q16.16 samples
// in raster order on the samples channel, one word per valid/ready handshake. For each
// interior point one word leaves on the results channel: scale*(4c-n-s-e-w) rounded to
// Q16.16, clipped with a saturated flag, frame_last set on the frame's last point.
// The cfg channel writes registers by index (always ready); write only when the core
// is idle. A write to grid_cols or grid_rows restarts the frame at its first sample.
// Throughput: one sample per cycle while samples.ready is high, set by the line memory,
// which takes one read and one write per sample. The result for center (r-1, c-1)
// leaves after the sample (r, c) is accepted, through the line memory read register, the
// queue, then magnitude, partial-product and round/clip stages in the back end.
// When the receiver stalls, the back end holds its words and the queue fills; the
// samples channel drops ready once the queue could not take the words in flight.
// Reset clears position, window, queue and pipeline and loads the register reset values;
// the line memory needs no clearing since each row is written before it is read.
`include "laplace_5point_stencil_core_defines.svh"

module laplace_5point_stencil_core #(
    parameter int MAX_COLS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    lps_sample_if.sink    samples,
    lps_result_if.source  results,
    lps_cfg_if.sink       cfg
);
    import lps_pkg::*;

    // Configuration registers
    logic [COLS_W-1:0] grid_cols_reg;
    logic [ROWS_W-1:0] grid_rows_reg;
    logic [DATA_W-1:0] inv_h_squared_reg;
    logic              zero_border_reg;
    logic              negate_result_reg;
    logic              cfg_write;
    logic              restart;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;
    assign restart   = cfg_write &&
                       ((cfg.index == REG_GRID_COLS) || (cfg.index == REG_GRID_ROWS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg     <= COLS_W'(8);
            grid_rows_reg     <= ROWS_W'(8);
            inv_h_squared_reg <= 32'd5308416;
            zero_border_reg   <= 1'b0;
            negate_result_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg.index)
                REG_GRID_COLS:     grid_cols_reg     <= cfg.data[COLS_W-1:0];
                REG_GRID_ROWS:     grid_rows_reg     <= cfg.data[ROWS_W-1:0];
                REG_INV_H_SQUARED: inv_h_squared_reg <= cfg.data;
                REG_ZERO_BORDER:   zero_border_reg   <= cfg.data[0];
                REG_NEGATE_RESULT: negate_result_reg <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    front_cfg_t fcfg;
    back_cfg_t  bcfg;

    assign fcfg.grid_cols     = grid_cols_reg;
    assign fcfg.grid_rows     = grid_rows_reg;
    assign fcfg.zero_border   = zero_border_reg;
    assign fcfg.restart       = restart;
    assign bcfg.inv_h_squared = inv_h_squared_reg;
    assign bcfg.negate_result = negate_result_reg;

    logic      q_push;
    logic      q_pop;
    lap_word_t q_in;
    lap_word_t q_head;
    q_status_t q_status;

    lps_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .fcfg      (fcfg),
        .q_status  (q_status),
        .push      (q_push),
        .push_word (q_in)
    );

    lps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    lps_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .bcfg     (bcfg),
        .head     (q_head),
        .q_status (q_status),
        .pop      (q_pop),
        .results  (results)
    );

    // Self checks
    `LPS_ASSERT_IMPL(a_push_not_full, q_push, !q_status.full, "push into a full queue")
    `LPS_ASSERT_NEVER(a_pop_not_empty, q_pop && q_status.empty, "pop from an empty queue")
    `LPS_ASSERT_IMPL(a_sat_value, results.valid && results.saturated,
        results.value == VALUE_MAX || results.value == VALUE_MIN, "clipped word off limit")

endmodule

@@ tb/lps_stencil_checker.sv @@
// Scoreboard for the five-point Laplacian stencil core: watches the config, sample
// and result channels, predicts each stencil point and compares it field by field.
// Depends on lps_pkg and the channel interfaces in lps_ifs.
`timescale 1ns / 100ps

module lps_stencil_checker #(
    parameter int MAX_COLS = 1024
) (
    input  logic  clk,
    input  logic  rst_n,
    lps_sample_if samples,
    lps_result_if results,
    lps_cfg_if    cfg,
    output int    fail_count,
    output int    pending,
    output int    points_checked,
    output int    points_clipped,
    output int    frames_closed
);
    import lps_pkg::*;

    localparam int LINE_DEPTH = MAX_COLS + 2;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              frame_last;
        logic              saturated;
    } point_t;

    // Shadow copy of the register file
    logic [COLS_W-1:0] cols_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [DATA_W-1:0] scale_reg;
    logic              zero_border_reg;
    logic              negate_reg;

    // Shadow copy of the line buffers, window and raster position
    logic [DATA_W-1:0] upper_line  [LINE_DEPTH];
    logic [DATA_W-1:0] middle_line [LINE_DEPTH];
    longint            row_window  [3];
    longint            north_south;
    int unsigned       col_pos;
    int unsigned       row_pos;

    point_t expected_points [$];

    // Advance the stencil by one sample word; queue the point it completes, if any.
    task automatic advance_stencil(input logic [DATA_W-1:0] word);
        int unsigned        cols;
        int unsigned        rows;
        int unsigned        idx;
        logic [DATA_W-1:0]  raw;
        longint             north;
        longint             here;
        logic signed [63:0] lap;
        logic [63:0]        mag;
        logic [63:0]        q;
        logic [63:0]        neg_q;
        logic               neg;
        point_t             pt;
        cols = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
        rows = (rows_reg == 0) ? 1 : rows_reg;
        idx  = (col_pos < LINE_DEPTH) ? col_pos : LINE_DEPTH - 1;
        raw  = word;
        // Ghost ring forced to zero when asked
        if (zero_border_reg && (row_pos == 0 || row_pos >= rows + 1 ||
                                col_pos == 0 || col_pos >= cols + 1))
            raw = '0;
        north = longint'($signed(upper_line[idx]));
        here  = longint'($signed(raw));
        row_window[0] = row_window[1];
        row_window[1] = row_window[2];
        row_window[2] = longint'($signed(middle_line[idx]));

        if (row_pos >= 2 && col_pos >= 2 && row_pos <= rows + 1 && col_pos <= cols + 1)
        begin
            lap = 4 * row_window[1] - row_window[0] - row_window[2] - north_south;
            neg = (lap < 0);
            mag = neg ? -lap : lap;
            // Scale by Q16.16 factor, round half away from zero on the magnitude
            q = mag * {48'd0, scale_reg[31:16]} +
                ((mag * {48'd0, scale_reg[15:0]} + 64'h8000) >> 16);
            if (negate_reg)
                neg = !neg;
            if (q == 0)
                neg = 1'b0;
            pt.saturated = 1'b0;
            if (neg)
            begin
                if (q > 64'h8000_0000)
                begin
                    q            = 64'h8000_0000;
                    pt.saturated = 1'b1;
                end
                neg_q    = 64'd0 - q;
                pt.value = neg_q[DATA_W-1:0];
            end
            else
            begin
                if (q > 64'h7FFF_FFFF)
                begin
                    q            = 64'h7FFF_FFFF;
                    pt.saturated = 1'b1;
                end
                pt.value = q[DATA_W-1:0];
            end
            pt.frame_last = (row_pos == rows + 1 && col_pos == cols + 1);
            expected_points.push_back(pt);
        end
        north_south = north + here;

        upper_line[idx]  = middle_line[idx];
        middle_line[idx] = raw;

        // Step the raster position, wrapping at row and frame ends
        if (col_pos + 1 >= cols + 2)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= rows + 2) ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        if (!rst_n)
        begin
            cols_reg        = 8;
            rows_reg        = 8;
            scale_reg       = 32'd5308416;
            zero_border_reg = 1'b0;
            negate_reg      = 1'b0;
            for (int k = 0; k < LINE_DEPTH; k++)
            begin
                upper_line[k]  = '0;
                middle_line[k] = '0;
            end
            row_window[0] = 0;
            row_window[1] = 0;
            row_window[2] = 0;
            north_south   = 0;
            col_pos       = 0;
            row_pos       = 0;
            expected_points.delete();
            fail_count     = 0;
            points_checked = 0;
            points_clipped = 0;
            frames_closed  = 0;
            pending       <= 0;
        end
        else
        begin
            // Compare a delivered result word with the oldest prediction
            if (results.valid && results.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("result word with nothing expected: value %h", results.value);
                    fail_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    points_checked++;
                    if (want.saturated)
                        points_clipped++;
                    if (want.frame_last)
                        frames_closed++;
                    if (results.value !== want.value)
                    begin
                        $error("value: expected %h, got %h", want.value, results.value);
                        fail_count++;
                    end
                    if (results.frame_last !== want.frame_last)
                    begin
                        $error("frame_last: expected %b, got %b",
                               want.frame_last, results.frame_last);
                        fail_count++;
                    end
                    if (results.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %b, got %b",
                               want.saturated, results.saturated);
                        fail_count++;
                    end
                end
            end

            // Track register writes; geometry writes restart the frame
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_GRID_COLS:
                    begin
                        cols_reg = cfg.data[COLS_W-1:0];
                        col_pos  = 0;
                        row_pos  = 0;
                    end
                    REG_GRID_ROWS:
                    begin
                        rows_reg = cfg.data[ROWS_W-1:0];
                        col_pos  = 0;
                        row_pos  = 0;
                    end
                    REG_INV_H_SQUARED: scale_reg       = cfg.data;
                    REG_ZERO_BORDER:   zero_border_reg = cfg.data[0];
                    REG_NEGATE_RESULT: negate_reg      = cfg.data[0];
                    default: ;
                endcase
            end

            if (samples.valid && samples.ready)
                advance_stencil(samples.sample);

            pending <= expected_points.size();
        end
    end

endmodule

@@ tb/tb_laplace_5point_stencil_core.sv @@
// Top of the stencil core testbench: clock, reset, config writes, sample stream,
// result back-pressure and the verdict.
// Depends on lps_pkg, lps_ifs, the core and lps_stencil_checker.
`timescale 1ns / 100ps

module tb_laplace_5point_stencil_core;
    import lps_pkg::*;

    localparam int MAX_COLS        = 1024;
    localparam int RANDOM_SAMPLES  = 320;
    localparam int PARTIAL_SAMPLES = 40;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 200000;

    logic clk;
    logic rst_n;

    int fail_count;
    int pending;
    int points_checked;
    int points_clipped;
    int frames_closed;

    int cycle_count;
    int samples_sent;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_requests;
    int holds_served;
    int hold_left;

    lps_sample_if sample_ch ();
    lps_result_if result_ch ();
    lps_cfg_if    cfg_ch ();

    laplace_5point_stencil_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    lps_stencil_checker #(
        .MAX_COLS (MAX_COLS)
    ) scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (sample_ch),
        .results        (result_ch),
        .cfg            (cfg_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .points_checked (points_checked),
        .points_clipped (points_clipped),
        .frames_closed  (frames_closed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result back-pressure: random stalls, plus a long hold on request
    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic int frame_size(input int cols, input int rows);
        int c;
        int r;
        c = (cols < 1) ? 1 : (cols > MAX_COLS) ? MAX_COLS : cols;
        r = (rows < 1) ? 1 : rows;
        return (c + 2) * (r + 2);
    endfunction

    // Mostly small Q16.16 values, some full-range words and the extremes
    function automatic logic [DATA_W-1:0] rand_sample();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            5:             return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            6, 7:          return $urandom;
            default:
                case ($urandom_range(3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
        endcase
    endfunction

    // Offer one sample word after a random gap; hold valid for the next word
    task automatic send_sample(input logic [DATA_W-1:0] word);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= word;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        samples_sent++;
    endtask

    task automatic send_samples(input int count);
        repeat (count)
            send_sample(rand_sample());
    endtask

    // 3x3 frame for a single interior point
    task automatic point_frame(input logic [DATA_W-1:0] ring, input logic [DATA_W-1:0] center,
                               input bit random_ring);
        for (int k = 0; k < 9; k++)
            send_sample(k == 4 ? center : (random_ring ? rand_sample() : ring));
    endtask

    // Drop valid, wait for every predicted point, then let the pipeline drain
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] word);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= word;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Write the whole register file, sometimes preceded by an unmapped index
    task automatic program_core(input int cols, input int rows, input logic [31:0] scale,
                                input bit zero_border, input bit negate);
        if ($urandom_range(3) == 0)
            put_reg(CFG_IDX_W'($urandom_range(REG_NEGATE_RESULT + 1, (1 << CFG_IDX_W) - 1)),
                    $urandom);
        put_reg(REG_GRID_COLS, cols);
        put_reg(REG_GRID_ROWS, rows);
        put_reg(REG_INV_H_SQUARED, scale);
        put_reg(REG_ZERO_BORDER, 32'(zero_border));
        put_reg(REG_NEGATE_RESULT, 32'(negate));
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int          cols;
        int          rows;
        int          full;
        int          random_start;
        int          progress;
        logic [31:0] scale;
        clk                = 1'b0;
        rst_n              = 1'b0;
        sample_ch.valid    = 1'b0;
        sample_ch.sample   = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        result_ch.ready    = 1'b0;
        cycle_count        = 0;
        samples_sent       = 0;
        hold_requests      = 0;
        sender_idle_pct    = 27;
        receiver_stall_pct = 65;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // Single-point frames at the field extremes: clip high, clip low,
        // then ghost ring zeroed, negation and a rounding tie
        program_core(1, 1, 32'hFFFF_FFFF, 1'b0, 1'b0);
        point_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        settle();
        point_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        settle();
        program_core(1, 1, 32'h0000_2000, 1'b1, 1'b1);
        point_frame('0, 32'h0000_0001, 1'b1);
        settle();

        // Random geometries and scales, idling pattern changes by thirds
        random_start = samples_sent;
        while (samples_sent - random_start < RANDOM_SAMPLES)
        begin
            progress = samples_sent - random_start;
            if (progress < RANDOM_SAMPLES / 3)
            begin
                sender_idle_pct    = 27;
                receiver_stall_pct = 65;
            end
            else if (progress < 2 * RANDOM_SAMPLES / 3)
            begin
                sender_idle_pct    = 65;
                receiver_stall_pct = 27;
            end
            else
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            case ($urandom_range(9))
                0:       cols = 0;
                1:       cols = 1;
                2:       cols = 2;
                default: cols = $urandom_range(1, 12);
            endcase
            case ($urandom_range(9))
                0:       rows = 0;
                1:       rows = 1;
                2:       rows = 65535;
                default: rows = $urandom_range(1, 6);
            endcase
            case ($urandom_range(7))
                0:       scale = 32'h0000_0000;
                1:       scale = 32'h0001_0000;
                2:       scale = 32'h0000_2000;
                3:       scale = 32'h0051_0000;
                4:       scale = 32'hFFFF_FFFF;
                5:       scale = $urandom;
                default: scale = $urandom_range(0, 32'h000F_FFFF);
            endcase
            program_core(cols, rows, scale, 1'($urandom_range(1)), 1'($urandom_range(1)));
            full = frame_size(cols, rows);
            // Broken-off frames end with the next geometry write
            if (rows == 65535 || $urandom_range(9) == 0)
                send_samples($urandom_range(1, (full > 120) ? 120 : full - 1));
            else
                repeat ($urandom_range(1, 2))
                begin
                    send_samples(full);
                    if ($urandom_range(2) == 0)
                        settle();
                end
            settle();
        end

        // Clipped column count and zero row count: start of the widest row
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        program_core(2047, 0, 32'h0001_0000, 1'($urandom_range(1)), 1'b0);
        send_samples(PARTIAL_SAMPLES);
        settle();

        // Long result stall while the sender keeps offering, so the core
        // backs up onto its input
        program_core(12, 6, 32'h0001_0000, 1'($urandom_range(1)), 1'b0);
        hold_requests++;
        send_samples(frame_size(12, 6));
        settle();
        program_core(1024, 65535, $urandom, 1'b0, 1'b1);
        send_samples(PARTIAL_SAMPLES);
        settle();

        $display("streamed %0d samples; checked %0d stencil points, %0d clipped, %0d frame ends",
                 samples_sent, points_checked, points_clipped, frames_closed);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
